>>> design/pspl_pkg.sv
// ----------------------------------------------------------------------------
// pspl_pkg
// Shared widths, register codes and the types passed between the front end,
// the item queue and the arithmetic back end of the PID speed loop.
// ----------------------------------------------------------------------------
package pspl_pkg;

  localparam int DATA_WIDTH     = 16;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int ACC_WIDTH      = 40;

  localparam int GAIN_W  = 16;
  localparam int LIMIT_W = 15;
  localparam int DRIVE_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int ERR_W = DATA_WIDTH + 1;
  localparam int DLT_W = DATA_WIDTH + 2;
  localparam int P_W   = ERR_W + GAIN_W;
  localparam int D_W   = DLT_W + GAIN_W;
  localparam int INT_W = ((ACC_WIDTH > P_W) ? ACC_WIDTH : P_W) + 1;
  localparam int SUM_W = ((ACC_WIDTH > D_W) ? ACC_WIDTH : D_W) + 2;
  localparam int SHF_W = SUM_W - GAIN_FRAC_BITS;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = GAIN_W'(512);
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST   = '0;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST   = '0;
  localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RST = LIMIT_W'(2000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN    = 2'd0,
    REG_INTEG_GAIN   = 2'd1,
    REG_DERIV_GAIN   = 2'd2,
    REG_OUTPUT_LIMIT = 2'd3
  } pspl_reg_t;

  typedef struct packed {
    logic [ERR_W-1:0] err;
    logic [DLT_W-1:0] delta;
  } pspl_entry_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [LIMIT_W-1:0] output_limit;
  } pspl_cfg_t;

endpackage

>>> design/pspl_front.sv
// ----------------------------------------------------------------------------
// pspl_front
// Accepts control ticks, forms the speed error and its change since the last
// tick, and hands each item to the queue.
// ----------------------------------------------------------------------------
module pspl_front import pspl_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_target_speed,
  input  logic signed [DATA_WIDTH-1:0] in_measured_speed,
  output logic                         push,
  output pspl_entry_t                  push_entry,
  input  logic                         q_full
);

  logic                    fv_r;
  logic                    fv_nxt;
  pspl_entry_t             entry_r;
  logic signed [ERR_W-1:0] prev_err_r;
  logic signed [ERR_W-1:0] err_nxt;
  logic signed [DLT_W-1:0] delta_nxt;
  logic                    accept;

  assign in_stall   = fv_r && q_full;
  assign push       = fv_r && !q_full;
  assign push_entry = entry_r;
  assign accept     = in_valid && !in_stall;

  assign err_nxt   = ERR_W'(in_target_speed) - ERR_W'(in_measured_speed);
  assign delta_nxt = DLT_W'(err_nxt) - DLT_W'(prev_err_r);

  always_comb begin
    fv_nxt = fv_r;
    if (accept) begin
      fv_nxt = 1'b1;
    end else if (push) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r       <= 1'b0;
      prev_err_r <= '0;
    end else begin
      fv_r <= fv_nxt;
      if (accept) begin
        prev_err_r <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_r.err   <= err_nxt;
      entry_r.delta <= delta_nxt;
    end
  end

endmodule

>>> design/pspl_queue.sv
// ----------------------------------------------------------------------------
// pspl_queue
// Short first-in first-out queue of error items between front and back.
// ----------------------------------------------------------------------------
module pspl_queue import pspl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  pspl_entry_t push_entry,
  input  logic        pop,
  output logic        q_valid,
  output logic        q_full,
  output pspl_entry_t head
);

  pspl_entry_t      mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QAW:0]     count_r;
  logic [QAW:0]     count_nxt;
  logic             do_pop;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == (QAW+1)'(QDEPTH));
  assign head    = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> design/pspl_back.sv
// ----------------------------------------------------------------------------
// pspl_back
// Pipelined PID arithmetic: gain products, saturating integral, term sum,
// truncation toward zero and symmetric output saturation.
// ----------------------------------------------------------------------------
module pspl_back import pspl_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pspl_cfg_t                 cfg,
  input  logic                      q_valid,
  input  pspl_entry_t               head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DRIVE_W-1:0] out_drive_value,
  output logic                      out_was_clamped
);

  localparam logic signed [INT_W-1:0] ACC_MAX =
    {{(INT_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [INT_W-1:0] ACC_MIN =
    {{(INT_W-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};

  logic                        en;
  logic                        v1_r, v2_r, v3_r, v4_r, v5_r, vo_r;

  logic signed [ERR_W-1:0]     err1_r;
  logic signed [DLT_W-1:0]     dlt1_r;

  logic signed [P_W-1:0]       p2_r;
  logic signed [D_W-1:0]       d2_r;
  logic signed [P_W-1:0]       inc2_r;

  logic signed [ACC_WIDTH-1:0] integ_r;
  logic signed [INT_W-1:0]     integ_raw;
  logic signed [ACC_WIDTH-1:0] integ_nxt;

  logic signed [SUM_W-1:0]     pd3_r;
  logic signed [ACC_WIDTH-1:0] integ3_r;
  logic signed [SUM_W-1:0]     sum4_r;
  logic [SUM_W-1:0]            mag;
  logic                        neg5_r;
  logic [SHF_W-1:0]            shf5_r;
  logic                        clamp;
  logic [LIMIT_W-1:0]          val;
  logic [DRIVE_W-1:0]          mag_out;

  assign en        = !vo_r || !out_stall;
  assign pop       = en && q_valid;
  assign out_valid = vo_r;

  assign integ_raw = INT_W'(integ_r) + INT_W'(inc2_r);

  always_comb begin
    integ_nxt = integ_raw[ACC_WIDTH-1:0];
    if (integ_raw > ACC_MAX) begin
      integ_nxt = ACC_MAX[ACC_WIDTH-1:0];
    end else if (integ_raw < ACC_MIN) begin
      integ_nxt = ACC_MIN[ACC_WIDTH-1:0];
    end
  end

  assign mag     = sum4_r[SUM_W-1] ? SUM_W'(-sum4_r) : SUM_W'(sum4_r);
  assign clamp   = shf5_r > SHF_W'(cfg.output_limit);
  assign val     = clamp ? cfg.output_limit : shf5_r[LIMIT_W-1:0];
  assign mag_out = {1'b0, val};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      vo_r    <= 1'b0;
      integ_r <= '0;
    end else if (en) begin
      v1_r <= q_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      vo_r <= v5_r;
      if (v2_r) begin
        integ_r <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err1_r          <= head.err;
      dlt1_r          <= head.delta;
      p2_r            <= err1_r * $signed(cfg.prop_gain);
      d2_r            <= dlt1_r * $signed(cfg.deriv_gain);
      inc2_r          <= err1_r * $signed(cfg.integ_gain);
      pd3_r           <= SUM_W'(p2_r) + SUM_W'(d2_r);
      integ3_r        <= integ_nxt;
      sum4_r          <= pd3_r + SUM_W'(integ3_r);
      neg5_r          <= sum4_r[SUM_W-1];
      shf5_r          <= mag[SUM_W-1:GAIN_FRAC_BITS];
      out_was_clamped <= clamp;
      out_drive_value <= neg5_r ? -mag_out : mag_out;
    end
  end

endmodule

>>> design/positional_pid_speed_loop.sv
// ----------------------------------------------------------------------------
// positional_pid_speed_loop
// Positional PID speed controller: one drive value per control tick.
// ----------------------------------------------------------------------------
// Takes one tick per clock while in_stall is low. A tick is registered in
// the front end, where the error is formed, then passes through the
// four-entry item queue and the back-end pipeline. The sustained rate of one
// item per cycle, while the output is not stalled, is set by the integral
// update, a single saturating add that each item completes in one stage. A
// stalled output holds the back end while the queue keeps taking ticks until
// it fills. The user must write gains and the output limit through the cfg
// port only while no tick is in flight (unenforced); cfg_ready is always high.
module positional_pid_speed_loop import pspl_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_target_speed,
  input  logic signed [DATA_WIDTH-1:0] in_measured_speed,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DRIVE_W-1:0]    out_drive_value,
  output logic                         out_was_clamped,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  pspl_cfg_t   cfg_r;
  logic        push;
  pspl_entry_t push_entry;
  logic        q_full;
  logic        q_valid;
  pspl_entry_t head;
  logic        pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain    <= PROP_GAIN_RST;
      cfg_r.integ_gain   <= INTEG_GAIN_RST;
      cfg_r.deriv_gain   <= DERIV_GAIN_RST;
      cfg_r.output_limit <= OUTPUT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pspl_reg_t'(cfg_index))
        REG_PROP_GAIN:    cfg_r.prop_gain    <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:   cfg_r.integ_gain   <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:   cfg_r.deriv_gain   <= cfg_data[GAIN_W-1:0];
        REG_OUTPUT_LIMIT: cfg_r.output_limit <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pspl_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_target_speed   (in_target_speed),
    .in_measured_speed (in_measured_speed),
    .push              (push),
    .push_entry        (push_entry),
    .q_full            (q_full)
  );

  pspl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_full     (q_full),
    .head       (head)
  );

  pspl_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drive_value (out_drive_value),
    .out_was_clamped (out_was_clamped)
  );

endmodule

>>> design/pspl_checker.sv
// ----------------------------------------------------------------------------
// pspl_checker
// Port-level checks on the PID speed loop, bound to the top level.
// ----------------------------------------------------------------------------
module pspl_checker import pspl_pkg::*; (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic signed [DATA_WIDTH-1:0] in_target_speed,
  input logic signed [DATA_WIDTH-1:0] in_measured_speed,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [DRIVE_W-1:0]    out_drive_value,
  input logic                         out_was_clamped
);

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_reset_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=>
      in_valid && $stable(in_target_speed) && $stable(in_measured_speed))
    else $error("stalled input item changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_drive_value) && $stable(out_was_clamped))
    else $error("stalled result changed");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive_value != {1'b1, {(DRIVE_W-1){1'b0}}})
    else $error("drive value outside symmetric range");

endmodule

bind positional_pid_speed_loop pspl_checker u_pspl_checker (.*);
